>>> rtl/gmdt_pkg.sv
// Shared constants and types for the greedy minimum-distance point thinning block.
// No dependencies; every other rtl file imports this package.
package gmdt_pkg;

    localparam int DEF_MAX_KEPT   = 1024;
    localparam int DEF_COORD_BITS = 24;

    localparam int MIN_DIST_W     = 25;
    localparam int LIMIT_W        = 2 * MIN_DIST_W;
    localparam int TOTAL_W        = 11;
    localparam int INFLIGHT_W     = 3;

    localparam logic [MIN_DIST_W-1:0] MIN_DIST_RESET = MIN_DIST_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } gmdt_state_t;

endpackage

>>> rtl/gmdt_store.sv
// Kept-point memory: one synchronous RAM holding x and y of each kept point.
// One write port and one read port, registered read data. Depends on gmdt_pkg.
module gmdt_store
    import gmdt_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_KEPT,
    parameter int WORD_W = 2 * DEF_COORD_BITS,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_valid,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

endmodule

>>> rtl/gmdt_dist.sv
// Three-stage squared-distance pipeline: difference magnitudes, squares, then
// sum and compare against the squared minimum distance. Depends on gmdt_pkg.
module gmdt_dist
    import gmdt_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic        [LIMIT_W-1:0]    limit,
    input  logic                         sample_valid,
    input  logic signed [COORD_BITS-1:0] sx,
    input  logic signed [COORD_BITS-1:0] sy,
    output logic                         hit_valid,
    output logic                         hit
);

    localparam int DW   = COORD_BITS + 1;
    localparam int SQW  = 2 * DW;
    localparam int SUMW = SQW + 1;
    localparam int CMPW = (SUMW > LIMIT_W) ? SUMW : LIMIT_W;

    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic        [DW-1:0]   mag_x_reg;
    logic        [DW-1:0]   mag_y_reg;
    logic        [SQW-1:0]  sq_x_reg;
    logic        [SQW-1:0]  sq_y_reg;
    logic        [SUMW-1:0] sum;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   hit_reg;

    assign dx  = DW'(px) - DW'(sx);
    assign dy  = DW'(py) - DW'(sy);
    assign sum = SUMW'(sq_x_reg) + SUMW'(sq_y_reg);

    always_ff @(posedge clk)
    begin
        mag_x_reg <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        mag_y_reg <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        sq_x_reg  <= SQW'(mag_x_reg) * SQW'(mag_x_reg);
        sq_y_reg  <= SQW'(mag_y_reg) * SQW'(mag_y_reg);
        hit_reg   <= CMPW'(sum) < CMPW'(limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= sample_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign hit_valid = v3_reg;
    assign hit       = hit_reg;

endmodule

>>> rtl/greedy_min_distance_point_thinning_unit.sv
// Greedy minimum-distance point thinning: keeps a point only if it lies at least
// the minimum spacing from every point kept so far. Depends on gmdt_pkg, gmdt_store, gmdt_dist.
//
// Each input transfer carries one point. The block scans its kept-point memory,
// reading one stored point per cycle, and feeds each into a three-stage
// squared-distance pipeline that compares dx*dx + dy*dy against the minimum spacing
// squared (the square is formed once when the register is written). The scan
// stops issuing reads once the pipeline reports a stored point that is too close.
// A point that passes is appended to the memory; if the memory already holds
// MAX_KEPT points it is reported with keep and store_full set and is not stored.
// start_set empties the memory before the point is tested. The scan covers all
// kept points, or fewer when a close point ends it early, and the single memory
// read port reads them one after another. A new point is taken while the
// previous result still waits in the output register. The memory contents are
// undefined after reset and need no clearing pass: only entries below the kept
// count are ever read.
// The spacing register may only be written while the block is idle.
module greedy_min_distance_point_thinning_unit
    import gmdt_pkg::*;
#(
    parameter int MAX_KEPT   = DEF_MAX_KEPT,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [MIN_DIST_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         start_set,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         keep,
    output logic                         store_full,
    output logic [TOTAL_W-1:0]           kept_total
);

    localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW     = $clog2(MAX_KEPT + 1);
    localparam int WORD_W = 2 * COORD_BITS;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_KEPT);

    gmdt_state_t state_reg;
    gmdt_state_t state_next;

    logic [LIMIT_W-1:0]           limit_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                idx_next;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic                         hit_acc_reg;
    logic                         hit_acc_next;
    logic [INFLIGHT_W-1:0]        inflight_reg;
    logic [INFLIGHT_W-1:0]        inflight_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         keep_reg;
    logic                         keep_next;
    logic                         full_reg;
    logic                         full_next;
    logic [TOTAL_W-1:0]           total_reg;
    logic [TOTAL_W-1:0]           total_next;

    logic                         in_xfer;
    logic                         rd_en;
    logic                         wr_en;
    logic                         rd_valid;
    logic [WORD_W-1:0]            rd_data;
    logic                         hit_valid;
    logic                         hit;
    logic                         qualifies;
    logic                         slot_free;

    // The configuration register is always ready; the squared limit is formed here.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(MIN_DIST_RESET) * LIMIT_W'(MIN_DIST_RESET);
        end
        else if (cfg_valid)
        begin
            limit_reg <= LIMIT_W'(cfg_data) * LIMIT_W'(cfg_data);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign qualifies = !hit_acc_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    gmdt_store #(
        .DEPTH  (MAX_KEPT),
        .WORD_W (WORD_W),
        .ADDR_W (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[AW-1:0]),
        .wr_data  ({px_reg, py_reg}),
        .rd_en    (rd_en),
        .rd_addr  (idx_reg[AW-1:0]),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    gmdt_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .px           (px_reg),
        .py           (py_reg),
        .limit        (limit_reg),
        .sample_valid (rd_valid),
        .sx           (rd_data[WORD_W-1:COORD_BITS]),
        .sy           (rd_data[COORD_BITS-1:0]),
        .hit_valid    (hit_valid),
        .hit          (hit)
    );

    // Sequencer: scan the kept points, wait for the pipeline to empty, then
    // deliver the result and append the point when it passes and the memory is not full.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        hit_acc_next   = hit_acc_reg || (hit_valid && hit);
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        keep_next      = keep_reg;
        full_next      = full_reg;
        total_next     = total_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next     = '0;
                    hit_acc_next = 1'b0;
                    if (start_set)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit_acc_reg || (idx_reg == count_reg))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (inflight_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    keep_next      = qualifies;
                    full_next      = qualifies && (count_reg == MAX_COUNT);
                    if (qualifies && (count_reg != MAX_COUNT))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    total_next = TOTAL_W'(count_next);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        inflight_next = inflight_reg + INFLIGHT_W'(rd_en) - INFLIGHT_W'(hit_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            hit_acc_reg   <= 1'b0;
            inflight_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            hit_acc_reg   <= hit_acc_next;
            inflight_reg  <= inflight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        keep_reg  <= keep_next;
        full_reg  <= full_next;
        total_reg <= total_next;
    end

    assign out_valid  = out_valid_reg;
    assign keep       = keep_reg;
    assign store_full = full_reg;
    assign kept_total = total_reg;

endmodule

>>> bench/thinning_checker.sv
`timescale 1ns / 100ps
// Result checker for the greedy minimum-distance point thinning unit.
// Keeps its own kept-point store, predicts one verdict per point and compares results.
// Depends on gmdt_pkg for the register and count widths.
module thinning_checker
    import gmdt_pkg::*;
#(
    parameter int MAX_KEPT   = DEF_MAX_KEPT,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [MIN_DIST_W-1:0]        cfg_data,

    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         start_set,

    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         keep,
    input  logic                         store_full,
    input  logic [TOTAL_W-1:0]           kept_total,

    output int unsigned                  mismatch_count,
    output int unsigned                  pending_verdicts
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               keep;
        logic               store_full;
        logic [TOTAL_W-1:0] kept_total;
    } verdict_t;

    logic signed [COORD_BITS-1:0] kept_x [MAX_KEPT];
    logic signed [COORD_BITS-1:0] kept_y [MAX_KEPT];
    int unsigned                  kept_count;
    logic [MIN_DIST_W-1:0]        min_dist;
    verdict_t                     expected_verdicts [$];
    int unsigned                  errors;
    verdict_t                     seen;
    verdict_t                     want;

    // Tests one point against the kept store and updates the store the way the block must.
    function automatic verdict_t thin_point(input logic signed [COORD_BITS-1:0] px,
                                            input logic signed [COORD_BITS-1:0] py,
                                            input logic fresh_set);
        verdict_t v;
        longint   limit;
        longint   dx;
        longint   dy;
        logic     clear;
        limit = longint'(min_dist) * longint'(min_dist);
        clear = 1'b1;
        if (fresh_set)
            kept_count = 0;
        for (int i = 0; i < kept_count && clear; i++) begin
            dx = longint'(px) - longint'(kept_x[i]);
            dy = longint'(py) - longint'(kept_y[i]);
            if (dx * dx + dy * dy < limit)
                clear = 1'b0;
        end
        v.keep       = clear;
        v.store_full = 1'b0;
        if (clear) begin
            if (kept_count < MAX_KEPT) begin
                kept_x[kept_count] = px;
                kept_y[kept_count] = py;
                kept_count++;
            end else begin
                v.store_full = 1'b1;
            end
        end
        v.kept_total = kept_count[TOTAL_W-1:0];
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count = 0;
            min_dist   = MIN_DIST_RESET;
            errors     = 0;
            expected_verdicts.delete();
            mismatch_count   <= 0;
            pending_verdicts <= 0;
        end
        else
        begin
            // Results are matched before new points are queued; a result can never
            // belong to a point accepted at the same edge.
            if (out_valid && !out_stall)
            begin
                seen = {keep, store_full, kept_total};
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected result: keep=%0d store_full=%0d kept_total=%0d",
                                 $time, seen.keep, seen.store_full, seen.kept_total);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected keep=%0d store_full=%0d kept_total=%0d",
                                     $time, want.keep, want.store_full, want.kept_total);
                            $display("%0t: actual   keep=%0d store_full=%0d kept_total=%0d",
                                     $time, seen.keep, seen.store_full, seen.kept_total);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                min_dist = cfg_data;
            if (in_valid && !in_stall)
                expected_verdicts.insert(expected_verdicts.size(),
                                         thin_point(point_x, point_y, start_set));
            mismatch_count   <= errors;
            pending_verdicts <= expected_verdicts.size();
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the testbench for the greedy minimum-distance point thinning unit: clock, reset,
// stimulus and verdict. Depends on gmdt_pkg, the block itself and thinning_checker.
module tb_top
    import gmdt_pkg::*;
();

    localparam int MAX_KEPT      = DEF_MAX_KEPT;
    localparam int COORD_W       = DEF_COORD_BITS;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 4;
    // This pause is comfortably longer than the time the block needs beyond its scan.
    localparam int SETTLE_CYCLES = 16;
    // Even if every point landed in one growing store, each item scans at most a few
    // hundred entries, so a correct run ends well within this limit, even with the
    // longest stalls.
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int PHASE_ITEMS   = 70;
    localparam int PHASE_ROUNDS  = 2;
    localparam int MAX_SET_LEN   = 30;

    localparam logic [MIN_DIST_W-1:0]    MIN_DIST_MAX = '1;
    localparam logic signed [COORD_W-1:0] COORD_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [MIN_DIST_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      start_set;
    logic                      out_valid;
    logic                      out_stall;
    logic                      keep;
    logic                      store_full;
    logic [TOTAL_W-1:0]        kept_total;

    int unsigned mismatch_count;
    int unsigned pending_verdicts;
    int          idle_pct;
    int          stall_pct;
    int          cycle_count;

    greedy_min_distance_point_thinning_unit #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .start_set  (start_set),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .keep       (keep),
        .store_full (store_full),
        .kept_total (kept_total)
    );

    thinning_checker #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_W)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .point_x          (point_x),
        .point_y          (point_y),
        .start_set        (start_set),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .keep             (keep),
        .store_full       (store_full),
        .kept_total       (kept_total),
        .mismatch_count   (mismatch_count),
        .pending_verdicts (pending_verdicts)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // The result side stalls at random; stall_pct is changed with nonblocking
    // assignments so this process always sees a settled value.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one point and returns at the edge where the transfer happens. Valid is left
    // high on purpose: the next call either raises it again with a new payload or lowers
    // it for a gap, so it never sees two assignments in one time step.
    task automatic send_point(input int x,
                              input int y,
                              input logic fresh);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        point_x   <= COORD_W'(x);
        point_y   <= COORD_W'(y);
        start_set <= fresh;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Waits until every queued verdict has come back, then lets the pipeline empty.
    // The first edge is always taken so that the checker has seen the last transfer.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // The register is only written while the block is idle.
    task automatic write_spacing(input logic [MIN_DIST_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          sent;
        int          set_len;
        int          cx;
        int          cy;
        int          spread;
        int unsigned current_md;
        logic        fresh;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        point_x   = '0;
        point_y   = '0;
        start_set = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset spacing of one unit: coordinate extremes, an exact
        // duplicate (rejected), a neighbor exactly one unit away (kept), and a new set
        // that drops everything stored so far.
        send_point(int'(COORD_MAX), int'(COORD_MAX), 1'b1);
        send_point(int'(COORD_MIN), int'(COORD_MIN), 1'b0);
        send_point(int'(COORD_MIN), int'(COORD_MIN), 1'b0);
        send_point(int'(COORD_MIN) + 1, int'(COORD_MIN), 1'b0);
        send_point(0, 0, 1'b0);
        send_point(-1, -1, 1'b0);
        send_point(0, 0, 1'b1);

        // Zero spacing keeps every point, duplicates included.
        write_spacing('0);
        send_point(0, 0, 1'b0);
        send_point(0, 0, 1'b0);

        // The largest spacing exceeds any distance on the grid: only the first point of
        // a set survives, even against the opposite corner.
        write_spacing(MIN_DIST_MAX);
        send_point(int'(COORD_MIN), int'(COORD_MAX), 1'b1);
        send_point(int'(COORD_MAX), int'(COORD_MIN), 1'b0);
        send_point(int'(COORD_MAX), int'(COORD_MAX), 1'b0);

        // A 3-4-5 triangle sits exactly on the boundary and must be kept; one unit
        // closer is rejected.
        write_spacing(MIN_DIST_W'(5));
        send_point(0, 0, 1'b1);
        send_point(3, 4, 1'b0);
        send_point(3, 3, 1'b0);
        send_point(-3, -4, 1'b0);

        // Random phases. Most items come in clusters that start a new set around a random
        // center, spread over about twice the spacing so that keep and reject both occur
        // often. A few clusters carry on the previous store, and some items are noise:
        // anywhere on the grid with a random start bit.
        for (int round = 0; round < PHASE_ROUNDS; round++)
        begin
            for (int mode = 0; mode < 4; mode++)
            begin
                case ($urandom_range(9))
                    0:       current_md = 0;
                    1:       current_md = MIN_DIST_MAX;
                    2:       current_md = $urandom_range(MIN_DIST_MAX);
                    default: current_md = $urandom_range(64, 1);
                endcase
                write_spacing(current_md[MIN_DIST_W-1:0]);
                case (mode)
                    0:
                    begin
                        idle_pct  = 0;
                        stall_pct <= 0;
                    end
                    1:
                    begin
                        idle_pct  = 85;
                        stall_pct <= 0;
                    end
                    2:
                    begin
                        idle_pct  = 0;
                        stall_pct <= 85;
                    end
                    default:
                    begin
                        idle_pct  = 26;
                        stall_pct <= 26;
                    end
                endcase
                spread = (current_md > 1_000_000) ? 8_388_607 : 2 * current_md + 2;
                sent = 0;
                while (sent < PHASE_ITEMS)
                begin
                    set_len = $urandom_range(MAX_SET_LEN, 1);
                    cx      = int'($urandom);
                    cy      = int'($urandom);
                    fresh   = ($urandom_range(19) != 0);
                    for (int k = 0; k < set_len && sent < PHASE_ITEMS; k++)
                    begin
                        if ($urandom_range(9) == 0)
                            send_point(int'($urandom), int'($urandom), 1'($urandom_range(1)));
                        else
                            send_point(cx + int'($urandom_range(2 * spread)) - spread,
                                       cy + int'($urandom_range(2 * spread)) - spread,
                                       fresh && k == 0);
                        sent++;
                    end
                end
            end
        end

        // Let the result side run freely so the final results drain quickly.
        stall_pct <= 0;
        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> greedy_min_distance_point_thinning_unit.f
rtl/gmdt_pkg.sv
rtl/gmdt_store.sv
rtl/gmdt_dist.sv
rtl/greedy_min_distance_point_thinning_unit.sv
bench/thinning_checker.sv
bench/tb_top.sv
